// File: rtl/core/idpf_pkg.sv
// Shared types, codes and constants for the idle display power state machine.
package idpf_pkg;

   localparam int unsigned TIMEOUT_W = 32;
   localparam int unsigned LEVEL_W   = 7;
   localparam int unsigned MASK_W    = 5;
   localparam int unsigned CSR_IDX_W = 3;

   // Event kinds
   localparam logic [1:0] KIND_ACTIVITY = 2'd0;
   localparam logic [1:0] KIND_TICK     = 2'd1;
   localparam logic [1:0] KIND_INHIBIT  = 2'd2;

   // Power modes
   localparam logic MODE_ACTIVE = 1'b0;
   localparam logic MODE_IDLE   = 1'b1;

   // Reasons for the last mode change
   localparam logic [1:0] WHY_STARTUP    = 2'd0;
   localparam logic [1:0] WHY_ACTIVITY   = 2'd1;
   localparam logic [1:0] WHY_INACTIVITY = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TO      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_TO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_TO     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSPEND_TO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_LEVEL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_SUSPEND = 3'd6;

   // Register reset values
   localparam logic [TIMEOUT_W-1:0] RST_IDLE_TO      = 32'd30000;
   localparam logic [TIMEOUT_W-1:0] RST_SCREEN_TO    = 32'd60000;
   localparam logic [TIMEOUT_W-1:0] RST_PANEL_TO     = 32'd120000;
   localparam logic [TIMEOUT_W-1:0] RST_SUSPEND_TO   = 32'd300000;
   localparam logic [LEVEL_W-1:0]   RST_ACTIVE_LEVEL = 7'd80;
   localparam logic [LEVEL_W-1:0]   RST_DIM_LEVEL    = 7'd30;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

   // Which deadlines are live for the post-update state
   typedef struct packed {
      logic inhibited;
      logic idle;
      logic screen_en;
      logic panel_en;
      logic suspend_en;
   } dl_ctrl_type;

   function automatic logic [LEVEL_W-1:0] cap_level(input logic [LEVEL_W-1:0] v);
      return (v > LEVEL_MAX) ? LEVEL_MAX : v;
   endfunction

endpackage

// File: rtl/core/idle_display_power_fsm_top.sv
// Throughput: one event per cycle while rsp_ready does not hold the output; the input
// register feeds a single state-update stage, then a deadline stage (saturating sums and
// a 3-way minimum) loads the response register.
// Reset (synchronous, active high): mode active, reason startup, last activity 0, no
// inhibitors, flags clear, panel on, backlight at the default active level, registers
// back to their default values, pipeline empty.
module idle_display_power_fsm_top
   import idpf_pkg::*;
#(
   parameter int unsigned TIME_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic [TIME_BITS-1:0] req_now_ms,
   input  logic [TIME_BITS-1:0] req_event_ms,
   input  logic [MASK_W-1:0]    req_inhibitor_mask,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_power_state,
   output logic [1:0]           rsp_change_reason,
   output logic [LEVEL_W-1:0]   rsp_backlight_level,
   output logic                 rsp_panel_on,
   output logic                 rsp_screen_off_flag,
   output logic                 rsp_panel_off_flag,
   output logic                 rsp_suspend_request,
   output logic [TIME_BITS-1:0] rsp_next_deadline_ms,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIMEOUT_W-1:0] csr_wdata
);

   localparam logic [TIME_BITS-1:0] TIME_ONES = '1;

   function automatic logic reach(input logic [TIME_BITS-1:0] now_v,
                                  input logic [TIME_BITS-1:0] t_v);
      return (t_v != TIME_ONES) && (now_v >= t_v);
   endfunction

   // configuration
   logic [TIMEOUT_W-1:0] idle_to_ff, screen_to_ff, panel_to_ff, suspend_to_ff;
   logic [LEVEL_W-1:0]   active_level_ff, dim_level_ff;
   logic                 auto_suspend_ff;

   // block state
   logic                 mode_ff, mode_in;
   logic [1:0]           reason_ff, reason_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [MASK_W-1:0]    inhib_ff, inhib_in;
   logic                 scr_seen_ff, scr_seen_in;
   logic                 pan_seen_ff, pan_seen_in;
   logic [LEVEL_W-1:0]   bl_ff, bl_in;
   logic                 panel_en_ff, panel_en_in;
   logic                 suspend_in;

   // stage 1: input register
   logic                 s1_valid_ff;
   logic [1:0]           s1_kind_ff;
   logic [TIME_BITS-1:0] s1_now_ff, s1_event_ff;
   logic [MASK_W-1:0]    s1_mask_ff;

   // stage 2: post-update snapshot
   logic                 s2_valid_ff;
   logic                 s2_mode_ff, s2_panel_ff, s2_scr_ff, s2_pan_ff, s2_susp_ff;
   logic [1:0]           s2_reason_ff;
   logic [LEVEL_W-1:0]   s2_bl_ff;
   logic [TIME_BITS-1:0] s2_last_ff;
   dl_ctrl_type          s2_ctrl_ff, dl_ctrl_in;
   logic [TIME_BITS-1:0] s2_deadline;

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_mode_ff, rsp_panel_ff, rsp_scr_ff, rsp_pan_ff, rsp_susp_ff;
   logic [1:0]           rsp_reason_ff;
   logic [LEVEL_W-1:0]   rsp_bl_ff;
   logic [TIME_BITS-1:0] rsp_deadline_ff;

   logic out_free, s2_ready, s1_ready, s1_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || out_free;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s1_fire   = s1_valid_ff && s2_ready;
   assign req_ready = s1_ready;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_to_ff      <= RST_IDLE_TO;
         screen_to_ff    <= RST_SCREEN_TO;
         panel_to_ff     <= RST_PANEL_TO;
         suspend_to_ff   <= RST_SUSPEND_TO;
         active_level_ff <= RST_ACTIVE_LEVEL;
         dim_level_ff    <= RST_DIM_LEVEL;
         auto_suspend_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IDLE_TO:      idle_to_ff      <= csr_wdata;
            CSR_SCREEN_TO:    screen_to_ff    <= csr_wdata;
            CSR_PANEL_TO:     panel_to_ff     <= csr_wdata;
            CSR_SUSPEND_TO:   suspend_to_ff   <= csr_wdata;
            CSR_ACTIVE_LEVEL: active_level_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_DIM_LEVEL:    dim_level_ff    <= csr_wdata[LEVEL_W-1:0];
            CSR_AUTO_SUSPEND: auto_suspend_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: event evaluation ----------------
   logic [TIME_BITS-1:0] idle_t, scr_t, pan_t, sus_t;
   logic                 idle_hit, scr_hit, pan_hit, sus_hit, tick_hit;
   logic [LEVEL_W-1:0]   act_lvl, dim_lvl, idle_lvl;

   idpf_sat_add #(.TIME_BITS(TIME_BITS)) u_add_idle (
      .base_ms(last_ff), .delta_ms(idle_to_ff), .sum_ms(idle_t));
   idpf_sat_add #(.TIME_BITS(TIME_BITS)) u_add_scr (
      .base_ms(last_ff), .delta_ms(screen_to_ff), .sum_ms(scr_t));
   idpf_sat_add #(.TIME_BITS(TIME_BITS)) u_add_pan (
      .base_ms(last_ff), .delta_ms(panel_to_ff), .sum_ms(pan_t));
   idpf_sat_add #(.TIME_BITS(TIME_BITS)) u_add_sus (
      .base_ms(last_ff), .delta_ms(suspend_to_ff), .sum_ms(sus_t));

   assign idle_hit = reach(s1_now_ff, idle_t);
   assign scr_hit  = (screen_to_ff != '0) && reach(s1_now_ff, scr_t);
   assign pan_hit  = (panel_to_ff != '0) && reach(s1_now_ff, pan_t);
   assign sus_hit  = auto_suspend_ff && reach(s1_now_ff, sus_t);

   // "now reached the earliest deadline" is the OR over each live deadline
   assign tick_hit = (inhib_ff == '0) &&
                     ((mode_ff == MODE_ACTIVE) ? idle_hit :
                      ((!scr_seen_ff && scr_hit) || (!pan_seen_ff && pan_hit) || sus_hit));

   assign act_lvl  = cap_level(active_level_ff);
   assign dim_lvl  = cap_level(dim_level_ff);
   assign idle_lvl = (dim_lvl < act_lvl) ? dim_lvl : act_lvl;

   always_comb begin
      mode_in     = mode_ff;
      reason_in   = reason_ff;
      last_in     = last_ff;
      inhib_in    = inhib_ff;
      scr_seen_in = scr_seen_ff;
      pan_seen_in = pan_seen_ff;
      bl_in       = bl_ff;
      panel_en_in = panel_en_ff;
      suspend_in  = 1'b0;
      case (s1_kind_ff)
         KIND_ACTIVITY: begin
            last_in = s1_event_ff;
            if (mode_ff == MODE_IDLE) begin
               mode_in   = MODE_ACTIVE;
               reason_in = WHY_ACTIVITY;
            end
            scr_seen_in = 1'b0;
            pan_seen_in = 1'b0;
            bl_in       = act_lvl;
            panel_en_in = 1'b1;
         end
         KIND_TICK: begin
            if (tick_hit) begin
               if (mode_ff == MODE_ACTIVE) begin
                  mode_in   = MODE_IDLE;
                  reason_in = WHY_INACTIVITY;
               end
               scr_seen_in = scr_hit;
               pan_seen_in = pan_hit;
               bl_in       = (scr_hit || pan_hit) ? '0 : idle_lvl;
               panel_en_in = !pan_hit;
               suspend_in  = sus_hit;
            end
         end
         KIND_INHIBIT: begin
            inhib_in = s1_mask_ff;
            if (s1_mask_ff != '0) begin
               if (mode_ff == MODE_IDLE) begin
                  mode_in   = MODE_ACTIVE;
                  reason_in = WHY_ACTIVITY;
               end
               scr_seen_in = 1'b0;
               pan_seen_in = 1'b0;
               bl_in       = act_lvl;
               panel_en_in = 1'b1;
            end else if (inhib_ff != '0) begin
               // mask cleared: counts as activity, display left as is
               last_in = s1_now_ff;
               if (mode_ff == MODE_IDLE) begin
                  mode_in   = MODE_ACTIVE;
                  reason_in = WHY_ACTIVITY;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      dl_ctrl_in.inhibited  = (inhib_in != '0);
      dl_ctrl_in.idle       = (mode_in == MODE_IDLE);
      dl_ctrl_in.screen_en  = !scr_seen_in && (screen_to_ff != '0);
      dl_ctrl_in.panel_en   = !pan_seen_in && (panel_to_ff != '0);
      dl_ctrl_in.suspend_en = auto_suspend_ff;
   end

   // state and stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_ACTIVE;
         reason_ff   <= WHY_STARTUP;
         last_ff     <= '0;
         inhib_ff    <= '0;
         scr_seen_ff <= 1'b0;
         pan_seen_ff <= 1'b0;
         bl_ff       <= RST_ACTIVE_LEVEL;
         panel_en_ff <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         if (s1_fire) begin
            mode_ff     <= mode_in;
            reason_ff   <= reason_in;
            last_ff     <= last_in;
            inhib_ff    <= inhib_in;
            scr_seen_ff <= scr_seen_in;
            pan_seen_ff <= pan_seen_in;
            bl_ff       <= bl_in;
            panel_en_ff <= panel_en_in;
         end
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_kind_ff  <= req_kind;
         s1_now_ff   <= req_now_ms;
         s1_event_ff <= req_event_ms;
         s1_mask_ff  <= req_inhibitor_mask;
      end
   end

   // ---------------- stage 2: deadline ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_mode_ff   <= mode_in;
         s2_reason_ff <= reason_in;
         s2_bl_ff     <= bl_in;
         s2_panel_ff  <= panel_en_in;
         s2_scr_ff    <= scr_seen_in;
         s2_pan_ff    <= pan_seen_in;
         s2_susp_ff   <= suspend_in;
         s2_last_ff   <= last_in;
         s2_ctrl_ff   <= dl_ctrl_in;
      end
   end

   idpf_deadline #(.TIME_BITS(TIME_BITS)) u_deadline (
      .ctrl        (s2_ctrl_ff),
      .last_ms     (s2_last_ff),
      .idle_to     (idle_to_ff),
      .screen_to   (screen_to_ff),
      .panel_to    (panel_to_ff),
      .suspend_to  (suspend_to_ff),
      .deadline_ms (s2_deadline)
   );

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_free) begin
         rsp_mode_ff     <= s2_mode_ff;
         rsp_reason_ff   <= s2_reason_ff;
         rsp_bl_ff       <= s2_bl_ff;
         rsp_panel_ff    <= s2_panel_ff;
         rsp_scr_ff      <= s2_scr_ff;
         rsp_pan_ff      <= s2_pan_ff;
         rsp_susp_ff     <= s2_susp_ff;
         rsp_deadline_ff <= s2_deadline;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_power_state      = rsp_mode_ff;
   assign rsp_change_reason    = rsp_reason_ff;
   assign rsp_backlight_level  = rsp_bl_ff;
   assign rsp_panel_on         = rsp_panel_ff;
   assign rsp_screen_off_flag  = rsp_scr_ff;
   assign rsp_panel_off_flag   = rsp_pan_ff;
   assign rsp_suspend_request  = rsp_susp_ff;
   assign rsp_next_deadline_ms = rsp_deadline_ff;

`ifndef NO_ASSERTIONS
   // panel-off flag and panel enable always move together
   a_panel_flag: assert property (@(posedge clock) disable iff (reset)
      pan_seen_ff == !panel_en_ff)
      else $error("panel-off flag and panel enable disagree");

   // a disabled panel is never lit
   a_panel_dark: assert property (@(posedge clock) disable iff (reset)
      !panel_en_ff |-> (bl_ff == '0))
      else $error("backlight on with panel disabled");

   // idle is only entered with no inhibitor, and any inhibitor forces active
   a_idle_uninhibited: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (inhib_ff == '0))
      else $error("idle while inhibited");

   // a suspend request only comes with an idle status
   a_suspend_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_susp_ff) |-> (rsp_mode_ff == MODE_IDLE))
      else $error("suspend request while active");
`endif

endmodule

// File: rtl/core/idpf_sat_add.sv
// Time plus timeout, saturating at all ones of the time range.
module idpf_sat_add
   import idpf_pkg::*;
#(
   parameter int unsigned TIME_BITS = 48
) (
   input  logic [TIME_BITS-1:0] base_ms,
   input  logic [TIMEOUT_W-1:0] delta_ms,
   output logic [TIME_BITS-1:0] sum_ms
);

   localparam int unsigned PAD_W = TIME_BITS + 1 - TIMEOUT_W;

   logic [TIME_BITS:0] sum_full;

   assign sum_full = {1'b0, base_ms} + {{PAD_W{1'b0}}, delta_ms};
   assign sum_ms   = sum_full[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_full[TIME_BITS-1:0];

endmodule

// File: rtl/core/idpf_deadline.sv
// Earliest next deadline from the post-update state.
module idpf_deadline
   import idpf_pkg::*;
#(
   parameter int unsigned TIME_BITS = 48
) (
   input  dl_ctrl_type          ctrl,
   input  logic [TIME_BITS-1:0] last_ms,
   input  logic [TIMEOUT_W-1:0] idle_to,
   input  logic [TIMEOUT_W-1:0] screen_to,
   input  logic [TIMEOUT_W-1:0] panel_to,
   input  logic [TIMEOUT_W-1:0] suspend_to,
   output logic [TIME_BITS-1:0] deadline_ms
);

   localparam logic [TIME_BITS-1:0] TIME_ONES = '1;

   logic [TIME_BITS-1:0] idle_t, scr_t, pan_t, sus_t;
   logic [TIME_BITS-1:0] c_scr, c_pan, c_sus, idle_min;
   logic                 scr_le_pan, scr_le_sus, pan_le_sus;

   idpf_sat_add #(.TIME_BITS(TIME_BITS)) u_add_idle (
      .base_ms(last_ms), .delta_ms(idle_to), .sum_ms(idle_t));
   idpf_sat_add #(.TIME_BITS(TIME_BITS)) u_add_scr (
      .base_ms(last_ms), .delta_ms(screen_to), .sum_ms(scr_t));
   idpf_sat_add #(.TIME_BITS(TIME_BITS)) u_add_pan (
      .base_ms(last_ms), .delta_ms(panel_to), .sum_ms(pan_t));
   idpf_sat_add #(.TIME_BITS(TIME_BITS)) u_add_sus (
      .base_ms(last_ms), .delta_ms(suspend_to), .sum_ms(sus_t));

   assign c_scr = ctrl.screen_en  ? scr_t : TIME_ONES;
   assign c_pan = ctrl.panel_en   ? pan_t : TIME_ONES;
   assign c_sus = ctrl.suspend_en ? sus_t : TIME_ONES;

   // three compares side by side, then a select
   assign scr_le_pan = (c_scr <= c_pan);
   assign scr_le_sus = (c_scr <= c_sus);
   assign pan_le_sus = (c_pan <= c_sus);

   always_comb begin
      if (scr_le_pan && scr_le_sus) begin
         idle_min = c_scr;
      end else if (pan_le_sus) begin
         idle_min = c_pan;
      end else begin
         idle_min = c_sus;
      end
   end

   always_comb begin
      if (ctrl.inhibited) begin
         deadline_ms = TIME_ONES;
      end else if (!ctrl.idle) begin
         deadline_ms = idle_t;
      end else begin
         deadline_ms = idle_min;
      end
   end

endmodule

// File: tb/sv/idle_display_power_fsm_top_tb.sv
// Self-checking testbench for the idle display power state machine top level.
module idle_display_power_fsm_top_tb;
   import idpf_pkg::*;

   localparam int unsigned TW = 48;
   localparam logic [TW-1:0] NEVER_MS = '1;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic               power_state;
      logic [1:0]         change_reason;
      logic [LEVEL_W-1:0] backlight_level;
      logic               panel_on;
      logic               screen_off_flag;
      logic               panel_off_flag;
      logic               suspend_request;
      logic [TW-1:0]      next_deadline_ms;
   } status_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_kind;
   logic [TW-1:0]        req_now_ms;
   logic [TW-1:0]        req_event_ms;
   logic [MASK_W-1:0]    req_inhibitor_mask;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_power_state;
   logic [1:0]           rsp_change_reason;
   logic [LEVEL_W-1:0]   rsp_backlight_level;
   logic                 rsp_panel_on;
   logic                 rsp_screen_off_flag;
   logic                 rsp_panel_off_flag;
   logic                 rsp_suspend_request;
   logic [TW-1:0]        rsp_next_deadline_ms;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIMEOUT_W-1:0] csr_wdata;

   idle_display_power_fsm_top #(.TIME_BITS(TW)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_now_ms(req_now_ms), .req_event_ms(req_event_ms),
      .req_inhibitor_mask(req_inhibitor_mask),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_power_state(rsp_power_state), .rsp_change_reason(rsp_change_reason),
      .rsp_backlight_level(rsp_backlight_level), .rsp_panel_on(rsp_panel_on),
      .rsp_screen_off_flag(rsp_screen_off_flag), .rsp_panel_off_flag(rsp_panel_off_flag),
      .rsp_suspend_request(rsp_suspend_request),
      .rsp_next_deadline_ms(rsp_next_deadline_ms),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of the registers
   logic [TIMEOUT_W-1:0] c_idle_to, c_screen_to, c_panel_to, c_susp_to;
   logic [LEVEL_W-1:0]   c_active_lvl, c_dim_lvl;
   logic                 c_auto_susp;

   // predictor copy of the state
   logic                 p_mode;
   logic [1:0]           p_reason;
   logic [TW-1:0]        p_last_act;
   logic [MASK_W-1:0]    p_inhib;
   logic                 p_scr_off, p_pnl_off;
   logic [LEVEL_W-1:0]   p_backlight;
   logic                 p_panel_en;

   status_type    pending_status[$];
   status_type    want, seen;
   int unsigned   fail_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   req_gap_pct = 0;
   int unsigned   rsp_stall_pct = 0;
   logic [TW-1:0] wall_ms;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------- predictor ----------------

   function automatic logic [TW-1:0] sat_sum(input logic [TW-1:0] a,
                                            input logic [TIMEOUT_W-1:0] b);
      logic [TW:0] s;
      s = {1'b0, a} + {{(TW + 1 - TIMEOUT_W){1'b0}}, b};
      return s[TW] ? NEVER_MS : s[TW-1:0];
   endfunction

   function automatic logic hit(input logic [TW-1:0] now_ms, input logic [TW-1:0] t);
      return (t != NEVER_MS) && (now_ms >= t);
   endfunction

   function automatic logic [TW-1:0] next_due();
      logic [TW-1:0] d, t;
      d = NEVER_MS;
      if (p_inhib != '0) return NEVER_MS;
      if (p_mode == MODE_ACTIVE) return sat_sum(p_last_act, c_idle_to);
      if (!p_scr_off && c_screen_to != 0) d = sat_sum(p_last_act, c_screen_to);
      if (!p_pnl_off && c_panel_to != 0) begin
         t = sat_sum(p_last_act, c_panel_to);
         if (t < d) d = t;
      end
      if (c_auto_susp) begin
         t = sat_sum(p_last_act, c_susp_to);
         if (t < d) d = t;
      end
      return d;
   endfunction

   function automatic void drive_panel(input logic [LEVEL_W-1:0] lvl, input logic on);
      p_panel_en  = on;
      p_backlight = on ? lvl : '0;
   endfunction

   function automatic void wake_up();
      if (p_mode == MODE_IDLE) begin
         p_mode   = MODE_ACTIVE;
         p_reason = WHY_ACTIVITY;
      end
   endfunction

   function automatic void relight_panel();
      p_scr_off = 1'b0;
      p_pnl_off = 1'b0;
      drive_panel((c_active_lvl > LEVEL_MAX) ? LEVEL_MAX : c_active_lvl, 1'b1);
   endfunction

   function automatic void power_reset();
      c_idle_to    = RST_IDLE_TO;
      c_screen_to  = RST_SCREEN_TO;
      c_panel_to   = RST_PANEL_TO;
      c_susp_to    = RST_SUSPEND_TO;
      c_active_lvl = RST_ACTIVE_LEVEL;
      c_dim_lvl    = RST_DIM_LEVEL;
      c_auto_susp  = 1'b0;
      p_mode       = MODE_ACTIVE;
      p_reason     = WHY_STARTUP;
      p_last_act   = '0;
      p_inhib      = '0;
      p_scr_off    = 1'b0;
      p_pnl_off    = 1'b0;
      p_backlight  = RST_ACTIVE_LEVEL;
      p_panel_en   = 1'b1;
   endfunction

   function automatic status_type power_step(input logic [1:0] kind,
                                             input logic [TW-1:0] now_ms,
                                             input logic [TW-1:0] event_ms,
                                             input logic [MASK_W-1:0] mask);
      status_type         r;
      logic               susp;
      logic [LEVEL_W-1:0] act, dim;
      logic [MASK_W-1:0]  prev;
      susp = 1'b0;
      case (kind)
         KIND_ACTIVITY: begin
            p_last_act = event_ms;
            wake_up();
            relight_panel();
         end
         KIND_TICK: begin
            if (hit(now_ms, next_due())) begin
               if (p_mode == MODE_ACTIVE) begin
                  p_mode   = MODE_IDLE;
                  p_reason = WHY_INACTIVITY;
               end
               act = (c_active_lvl > LEVEL_MAX) ? LEVEL_MAX : c_active_lvl;
               dim = (c_dim_lvl > LEVEL_MAX) ? LEVEL_MAX : c_dim_lvl;
               if (act < dim) dim = act;
               p_scr_off = (c_screen_to != 0) && hit(now_ms, sat_sum(p_last_act, c_screen_to));
               p_pnl_off = (c_panel_to != 0) && hit(now_ms, sat_sum(p_last_act, c_panel_to));
               drive_panel(p_scr_off ? '0 : dim, !p_pnl_off);
               susp = c_auto_susp && hit(now_ms, sat_sum(p_last_act, c_susp_to));
            end
         end
         KIND_INHIBIT: begin
            prev    = p_inhib;
            p_inhib = mask;
            if (mask != '0) begin
               wake_up();
               relight_panel();
            end else if (prev != '0) begin
               // clearing leaves the display alone
               p_last_act = now_ms;
               wake_up();
            end
         end
         default: ;
      endcase
      r.power_state      = p_mode;
      r.change_reason    = p_reason;
      r.backlight_level  = p_backlight;
      r.panel_on         = p_panel_en;
      r.screen_off_flag  = p_scr_off;
      r.panel_off_flag   = p_pnl_off;
      r.suspend_request  = susp;
      r.next_deadline_ms = next_due();
      return r;
   endfunction

   // ---------------- result checking ----------------

   function automatic void check_field(input string what, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_power_state, rsp_change_reason, rsp_backlight_level, rsp_panel_on,
                 rsp_screen_off_flag, rsp_panel_off_flag, rsp_suspend_request,
                 rsp_next_deadline_ms};
         if (pending_status.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response: expected none, actual %h", $time, seen);
         end else begin
            want = pending_status.pop_front();
            check_field("power_state", want.power_state, seen.power_state);
            check_field("change_reason", want.change_reason, seen.change_reason);
            check_field("backlight_level", want.backlight_level, seen.backlight_level);
            check_field("panel_on", want.panel_on, seen.panel_on);
            check_field("screen_off_flag", want.screen_off_flag, seen.screen_off_flag);
            check_field("panel_off_flag", want.panel_off_flag, seen.panel_off_flag);
            check_field("suspend_request", want.suspend_request, seen.suspend_request);
            check_field("next_deadline_ms", want.next_deadline_ms, seen.next_deadline_ms);
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   function automatic logic [TW-1:0] rand_ms();
      logic [63:0] x;
      x = {$urandom, $urandom};
      return x[TW-1:0];
   endfunction

   // Called at a clock edge; returns at the edge of the transfer.
   task automatic send_event(input logic [1:0] kind, input logic [TW-1:0] now_ms,
                             input logic [TW-1:0] event_ms, input logic [MASK_W-1:0] mask);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_now_ms         <= now_ms;
      req_event_ms       <= event_ms;
      req_inhibitor_mask <= mask;
      do @(posedge clock); while (!req_ready);
      pending_status.push_back(power_step(kind, now_ms, event_ms, mask));
   endtask

   task automatic wait_all_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIMEOUT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_IDLE_TO:      c_idle_to    = data;
         CSR_SCREEN_TO:    c_screen_to  = data;
         CSR_PANEL_TO:     c_panel_to   = data;
         CSR_SUSPEND_TO:   c_susp_to    = data;
         CSR_ACTIVE_LEVEL: c_active_lvl = data[LEVEL_W-1:0];
         CSR_DIM_LEVEL:    c_dim_lvl    = data[LEVEL_W-1:0];
         CSR_AUTO_SUSPEND: c_auto_susp  = data[0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [TIMEOUT_W-1:0] idle_to, screen_to, panel_to,
                                 susp_to, act_lvl, dim_lvl, auto_susp);
      wait_all_done();
      write_reg(CSR_IDLE_TO, idle_to);
      write_reg(CSR_SCREEN_TO, screen_to);
      write_reg(CSR_PANEL_TO, panel_to);
      write_reg(CSR_SUSPEND_TO, susp_to);
      write_reg(CSR_ACTIVE_LEVEL, act_lvl);
      write_reg(CSR_DIM_LEVEL, dim_lvl);
      write_reg(CSR_AUTO_SUSPEND, auto_susp);
   endtask

   // Ticks are the most common event and mostly aim at the reported deadline, so the idle sequence is walked through.
   task automatic random_event();
      logic [TW-1:0] due_at, t, ev;
      int unsigned   r;
      r      = $urandom_range(99);
      due_at = next_due();
      if (r < 45) begin
         if (due_at == NEVER_MS) t = wall_ms + TW'($urandom_range(0, 1000));
         else case ($urandom_range(3))
            0: t = due_at;
            1: t = due_at - TW'(1);
            2: t = due_at + TW'($urandom_range(1, 5000));
            default: t = wall_ms + TW'($urandom_range(0, 1000));
         endcase
         wall_ms = t;
         send_event(KIND_TICK, t, rand_ms(), MASK_W'($urandom));
      end else if (r < 70) begin
         ev = ($urandom_range(9) == 0) ? NEVER_MS - TW'($urandom_range(0, 70000))
                                       : wall_ms + TW'($urandom_range(0, 50));
         wall_ms = ev;
         send_event(KIND_ACTIVITY, ev + TW'($urandom_range(0, 50)), ev, MASK_W'($urandom));
      end else if (r < 85) begin
         wall_ms = wall_ms + TW'($urandom_range(0, 100));
         send_event(KIND_INHIBIT, wall_ms, rand_ms(),
                    $urandom_range(1) ? '0 : MASK_W'($urandom));
      end else if (r < 92) begin
         send_event(KIND_UNUSED, rand_ms(), rand_ms(), MASK_W'($urandom));
      end else begin
         send_event(2'($urandom), rand_ms(), rand_ms(), MASK_W'($urandom));
      end
   endtask

   function automatic logic [TIMEOUT_W-1:0] rand_timeout();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return $urandom;
         default: return $urandom_range(1, 2000);
      endcase
   endfunction

   // ---------------- tests ----------------

   task automatic test_reset_walkthrough();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      send_event(KIND_UNUSED, '0, '0, '0);
      send_event(KIND_TICK, 48'd29999, '0, '0);
      send_event(KIND_TICK, 48'd30000, '0, '0);        // goes idle and dims
      send_event(KIND_TICK, 48'd60000, '0, '0);        // screen off
      send_event(KIND_TICK, 48'd120000, '0, '0);       // panel off
      send_event(KIND_TICK, NEVER_MS, NEVER_MS, '1);
      send_event(KIND_ACTIVITY, 48'd130000, 48'd125000, '0);
      send_event(KIND_INHIBIT, 48'd130000, '0, 5'h1F);
      send_event(KIND_TICK, NEVER_MS - 1, '0, '0);     // inhibited, no effect
      send_event(KIND_INHIBIT, 48'd150000, '0, 5'h10);
      send_event(KIND_INHIBIT, 48'd200000, '0, '0);    // clear restarts idle timer
      send_event(KIND_INHIBIT, 48'd210000, '0, '0);
      send_event(KIND_TICK, 48'd230000, '0, '0);
      send_event(KIND_INHIBIT, 48'd231000, '0, 5'h01); // wakes from idle
      send_event(KIND_INHIBIT, 48'd240000, '0, '0);
      // sums that land on or beyond the top of the time range
      send_event(KIND_ACTIVITY, '0, NEVER_MS - 30000, '0);
      send_event(KIND_TICK, NEVER_MS, '0, '0);
      send_event(KIND_ACTIVITY, '0, NEVER_MS, '0);
      send_event(KIND_ACTIVITY, NEVER_MS, '0, '1);
      send_event(KIND_TICK, NEVER_MS - 1, '0, '0);     // idle, screen and panel timeouts at once
      send_event(KIND_UNUSED, NEVER_MS, NEVER_MS, '1);
      send_event(KIND_ACTIVITY, '0, '0, '0);
      apply_settings(RST_IDLE_TO, RST_SCREEN_TO, RST_PANEL_TO, RST_SUSPEND_TO,
                     TIMEOUT_W'(RST_ACTIVE_LEVEL), TIMEOUT_W'(RST_DIM_LEVEL), 32'd1);
      send_event(KIND_TICK, 48'd299999, '0, '0);
      send_event(KIND_TICK, 48'd300000, '0, '0);       // suspend request
   endtask

   task automatic test_short_timeouts();
      apply_settings(32'd100, 32'd300, 32'd600, 32'd900, 32'd100, 32'd100, 32'd1);
      req_gap_pct   = 68;
      rsp_stall_pct = 0;
      wall_ms       = 48'd1000;
      repeat (400) random_event();
   endtask

   task automatic test_max_timeouts_capped_levels();
      apply_settings('1, '1, '1, '1, 32'd127, 32'd127, 32'd1);
      req_gap_pct   = 0;
      rsp_stall_pct = 68;
      repeat (400) random_event();
   endtask

   task automatic test_zero_timeouts();
      apply_settings('0, '0, '0, '0, 32'd0, 32'd100, 32'd1);
      req_gap_pct   = 35;
      rsp_stall_pct = 35;
      repeat (200) random_event();
      apply_settings('0, 32'd50, '0, 32'd10, 32'd55, 32'd101, 32'd0);
      repeat (200) random_event();
   endtask

   task automatic test_random_settings();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      repeat (4) begin
         // level and enable writes carry junk in the unused upper bits
         apply_settings(rand_timeout(), rand_timeout(), rand_timeout(), rand_timeout(),
                        {$urandom} & ~32'h7F | $urandom_range(0, 127),
                        {$urandom} & ~32'h7F | $urandom_range(0, 127), $urandom);
         repeat (50) random_event();
         wait_all_done();
         repeat (50) random_event();
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_kind           <= KIND_ACTIVITY;
      req_now_ms         <= '0;
      req_event_ms       <= '0;
      req_inhibitor_mask <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_IDLE_TO;
      csr_wdata          <= '0;
      wall_ms            = '0;
      power_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_walkthrough();
      test_short_timeouts();
      test_max_timeouts_capped_levels();
      test_zero_timeouts();
      test_random_settings();
      wait_all_done();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
